>>> sv/urc_pkg.sv
// urc_pkg: shared types, constants and a helper function for the ultrasonic range controller
// no dependencies; used by ultrasonic_range_controller
`default_nettype none

package urc_pkg;

    // timing and counter sizes
    localparam int unsigned TICKS_PER_MS    = 1000;
    localparam int unsigned ECHO_WIDTH_BITS = 16;
    localparam int unsigned PS_W            = $clog2(TICKS_PER_MS + 1);
    localparam int unsigned PERIOD_W        = 10;
    localparam int unsigned PULSE_W         = 8;
    localparam int unsigned RANGE_W         = 10;
    localparam int unsigned DIST_W          = 15;
    localparam int unsigned BAND_W          = 3;
    localparam int unsigned NUM_BANDS       = 5;

    localparam logic [PULSE_W-1:0] LOW_TICKS = 8'd3;
    localparam int unsigned SOUND_DIV        = 58;
    localparam int unsigned DIST_MAX         = 32767;

    // floor(w*16/58) = (w * DIST_MUL) >> DIST_SHIFT, exact for w below 2^ECHO_WIDTH_BITS
    localparam int unsigned DIST_SHIFT = ECHO_WIDTH_BITS + 6;
    localparam longint unsigned DIST_MUL =
        ((64'd1 << (ECHO_WIDTH_BITS + 10)) + SOUND_DIV - 1) / SOUND_DIV;
    localparam int unsigned DIST_MUL_W  = $clog2(DIST_MUL + 1);
    localparam int unsigned DIST_PROD_W = ECHO_WIDTH_BITS + DIST_MUL_W;
    localparam int unsigned DIST_Q_W    = DIST_PROD_W - DIST_SHIFT;

    // band thresholds: pct * 58 * max_range, compared against width * 100
    localparam int unsigned THR_W = $clog2(100 * SOUND_DIV * ((1 << RANGE_W) - 1) + 1);
    localparam int unsigned LHS_W = ECHO_WIDTH_BITS + 7;
    localparam int unsigned CMP_W = (LHS_W > THR_W) ? LHS_W : THR_W;
    localparam int unsigned BAND_PCT [NUM_BANDS] = '{5, 25, 50, 75, 100};

    // configuration register indexes and reset values
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_PULSE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE      = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd60;
    localparam logic [PULSE_W-1:0]  PULSE_RESET  = 8'd10;
    localparam logic [RANGE_W-1:0]  RANGE_RESET  = 10'd400;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } trig_phase_t;

    function automatic logic [THR_W-1:0] band_thr(input logic [RANGE_W-1:0] range,
                                                  input int unsigned idx);
        logic [THR_W-1:0] scale;
        scale = THR_W'(BAND_PCT[idx] * SOUND_DIV);
        return scale * THR_W'(range);
    endfunction

endpackage

`default_nettype wire

>>> sv/ultrasonic_range_controller.sv
// ultrasonic_range_controller: trigger sequencer and echo-width ranger, one tick per transfer
// pipeline: each input transfer passes through the input register, then the result register
// throughput: one input transfer per cycle; m_tready stalls propagate back through s_tready
// reset (rst_n low, async): config returns to 60 ms / 10 us / 400 cm, counters and
//   last distance/band clear, trigger sequence starts on the first tick after reset
// depends on urc_pkg
`default_nettype none

module ultrasonic_range_controller (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_wen,
    input  wire logic [urc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [urc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [urc_pkg::IN_TDATA_W-1:0]       s_tdata,  // [0] echo_level, rest zero
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [0] trigger_level, [1] measure_done, [16:2] distance_q4, [19:17] range_band, rest zero
    output logic [urc_pkg::OUT_TDATA_W-1:0]           m_tdata
);

    // configuration
    logic [urc_pkg::PERIOD_W-1:0] period_cfg_reg;
    logic [urc_pkg::PULSE_W-1:0]  pulse_cfg_reg;
    logic [urc_pkg::THR_W-1:0]    thr_reg [urc_pkg::NUM_BANDS];

    // pipeline
    logic in_v_reg;
    logic echo_in_reg;
    logic out_v_reg;
    logic [urc_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic advance;
    logic fire;

    // state
    urc_pkg::trig_phase_t          phase_reg, phase_next, phase_eff;
    logic [urc_pkg::PULSE_W-1:0]   pcount_reg, pcount_next, pcount_eff;
    logic [urc_pkg::PERIOD_W-1:0]  period_reg, period_next, period_eff;
    logic [urc_pkg::PS_W-1:0]      ps_reg, ps_next;
    logic [urc_pkg::ECHO_WIDTH_BITS-1:0] width_reg, width_next;
    logic active_reg, active_next;
    logic prev_echo_reg;
    logic [urc_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [urc_pkg::BAND_W-1:0] band_reg, band_next;

    logic start;
    logic level;
    logic done;
    logic [urc_pkg::PULSE_W:0] pcount_inc;
    logic [urc_pkg::PS_W:0]    ps_inc;
    logic [urc_pkg::DIST_PROD_W-1:0] dist_prod;
    logic [urc_pkg::DIST_Q_W-1:0]    dist_quot;
    logic [urc_pkg::CMP_W-1:0]       lhs;
    logic [urc_pkg::BAND_W-1:0]      band_calc;

    assign advance  = !out_v_reg || m_tready;
    assign fire     = in_v_reg && advance;
    assign s_tready = !in_v_reg || advance;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    // configuration writes, band thresholds precomputed on a range write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_cfg_reg <= urc_pkg::PERIOD_RESET;
            pulse_cfg_reg  <= urc_pkg::PULSE_RESET;
            for (int i = 0; i < urc_pkg::NUM_BANDS; i++)
            begin
                thr_reg[i] <= urc_pkg::band_thr(urc_pkg::RANGE_RESET, i);
            end
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                urc_pkg::CFG_TRIGGER_PERIOD:
                begin
                    period_cfg_reg <= cfg_wdata[urc_pkg::PERIOD_W-1:0];
                end
                urc_pkg::CFG_TRIGGER_PULSE:
                begin
                    pulse_cfg_reg <= cfg_wdata[urc_pkg::PULSE_W-1:0];
                end
                urc_pkg::CFG_MAX_RANGE:
                begin
                    for (int i = 0; i < urc_pkg::NUM_BANDS; i++)
                    begin
                        thr_reg[i] <= urc_pkg::band_thr(cfg_wdata[urc_pkg::RANGE_W-1:0], i);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // trigger sequencing and millisecond timebase
    always_comb
    begin
        start      = (phase_reg == urc_pkg::PH_IDLE) && (period_reg == '0);
        phase_eff  = start ? urc_pkg::PH_LOW : phase_reg;
        pcount_eff = start ? '0 : pcount_reg;
        period_eff = start ? period_cfg_reg : period_reg;
        level      = (phase_eff == urc_pkg::PH_HIGH);
        pcount_inc = {1'b0, pcount_eff} + 1'b1;

        phase_next  = phase_eff;
        pcount_next = pcount_inc[urc_pkg::PULSE_W-1:0];
        case (phase_eff)
            urc_pkg::PH_LOW:
            begin
                if (pcount_inc >= {1'b0, urc_pkg::LOW_TICKS})
                begin
                    pcount_next = '0;
                    phase_next  = (pulse_cfg_reg == '0) ? urc_pkg::PH_IDLE : urc_pkg::PH_HIGH;
                end
            end
            urc_pkg::PH_HIGH:
            begin
                if (pcount_inc >= {1'b0, pulse_cfg_reg})
                begin
                    pcount_next = '0;
                    phase_next  = urc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next  = urc_pkg::PH_IDLE;
                pcount_next = '0;
            end
        endcase

        ps_inc      = {1'b0, ps_reg} + 1'b1;
        ps_next     = ps_inc[urc_pkg::PS_W-1:0];
        period_next = period_eff;
        if (ps_inc >= (urc_pkg::PS_W + 1)'(urc_pkg::TICKS_PER_MS))
        begin
            ps_next = '0;
            if (period_eff != '0)
            begin
                period_next = period_eff - 1'b1;
            end
        end
    end

    // echo width, distance and band
    always_comb
    begin
        dist_prod = urc_pkg::DIST_PROD_W'(width_reg)
                    * urc_pkg::DIST_PROD_W'(urc_pkg::DIST_MUL);
        dist_quot = dist_prod[urc_pkg::DIST_PROD_W-1:urc_pkg::DIST_SHIFT];
        lhs       = urc_pkg::CMP_W'(width_reg) * urc_pkg::CMP_W'(100);

        // thresholds rise with the band index, so the band is the count exceeded
        band_calc = '0;
        for (int i = 0; i < urc_pkg::NUM_BANDS; i++)
        begin
            if (lhs > urc_pkg::CMP_W'(thr_reg[i]))
            begin
                band_calc = band_calc + 1'b1;
            end
        end

        width_next  = width_reg;
        active_next = active_reg;
        dist_next   = dist_reg;
        band_next   = band_reg;
        done        = 1'b0;
        if (echo_in_reg && !prev_echo_reg)
        begin
            active_next = 1'b1;
            width_next  = urc_pkg::ECHO_WIDTH_BITS'(1);
        end
        else if (echo_in_reg && active_reg)
        begin
            if (width_reg != '1)
            begin
                width_next = width_reg + 1'b1;
            end
        end
        else if (!echo_in_reg && prev_echo_reg && active_reg)
        begin
            if (64'(dist_quot) > 64'(urc_pkg::DIST_MAX))
            begin
                dist_next = urc_pkg::DIST_W'(urc_pkg::DIST_MAX);
            end
            else
            begin
                dist_next = urc_pkg::DIST_W'(dist_quot);
            end
            band_next   = band_calc;
            active_next = 1'b0;
            done        = 1'b1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            echo_in_reg <= s_tdata[0];
        end
    end

    // state update and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg     <= 1'b0;
            phase_reg     <= urc_pkg::PH_IDLE;
            pcount_reg    <= '0;
            period_reg    <= '0;
            ps_reg        <= '0;
            width_reg     <= '0;
            active_reg    <= 1'b0;
            prev_echo_reg <= 1'b0;
            dist_reg      <= '0;
            band_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_v_reg <= in_v_reg;
            end
            if (fire)
            begin
                phase_reg     <= phase_next;
                pcount_reg    <= pcount_next;
                period_reg    <= period_next;
                ps_reg        <= ps_next;
                width_reg     <= width_next;
                active_reg    <= active_next;
                prev_echo_reg <= echo_in_reg;
                dist_reg      <= dist_next;
                band_reg      <= band_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {4'b0000, band_next, dist_next, done, level};
        end
    end

`ifndef SYNTHESIS
    // a pulse is only being timed while the echo is high
    assert property (@(posedge clk) disable iff (!rst_n) active_reg |-> prev_echo_reg)
        else $error("echo measurement active with echo low");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == urc_pkg::PH_LOW) |-> (pcount_reg < urc_pkg::LOW_TICKS))
        else $error("trigger low phase overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        band_reg <= urc_pkg::BAND_W'(urc_pkg::NUM_BANDS))
        else $error("range band out of range");

    // a held input item must not be dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !advance) |=> (in_v_reg && $stable(echo_in_reg)))
        else $error("stalled input item lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && m_tdata[1]) |-> !active_reg)
        else $error("measurement reported while echo still active");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for ultrasonic_range_controller, one echo tick per input transfer
// an in-bench model of trigger sequencing and echo ranging predicts every reading
// depends on urc_pkg and the ultrasonic_range_controller rtl
`timescale 1ns / 1ps

module tb_top;

    import urc_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned MAX_REPORTS  = 10;

    // reading layout on m_tdata
    localparam int unsigned TRIG_BIT = 0;
    localparam int unsigned DONE_BIT = 1;
    localparam int unsigned DIST_LSB = 2;
    localparam int unsigned BAND_LSB = DIST_LSB + DIST_W;
    localparam int unsigned PAD_LSB  = BAND_LSB + BAND_W;

    localparam int unsigned BAND_LIMIT_PCT [NUM_BANDS] = '{5, 25, 50, 75, 100};
    localparam logic [BAND_W-1:0] BAND_BEYOND = 3'd5;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [DIST_W-1:0] distance;
        logic              done;
        logic              trig;
    } range_reading_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = CFG_TRIGGER_PERIOD;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // model copy of the registers
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
    logic [PULSE_W-1:0]  cfg_pulse  = PULSE_RESET;
    logic [RANGE_W-1:0]  cfg_range  = RANGE_RESET;

    // model state
    trig_phase_t                trig_ph     = PH_IDLE;
    logic [PS_W-1:0]            ms_ticks    = '0;
    logic [PERIOD_W-1:0]        period_left = '0;
    logic [PULSE_W-1:0]         phase_ticks = '0;
    logic [ECHO_WIDTH_BITS-1:0] echo_ticks  = '0;
    logic                       echo_busy   = 1'b0;
    logic                       echo_prev   = 1'b0;
    logic [DIST_W-1:0]          dist_q4     = '0;
    logic [BAND_W-1:0]          band_now    = '0;

    range_reading_t pending_readings [$];
    int             mismatches  = 0;
    int             burst_left  = 0;
    int             hold_cycles = 0;

    always #5 clk = ~clk;

    ultrasonic_range_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic logic [BAND_W-1:0] band_for(input logic [ECHO_WIDTH_BITS-1:0] width);
        logic [63:0] scaled;
        scaled = 64'(width) * 64'd100;
        for (int i = 0; i < NUM_BANDS; i++)
            if (scaled <= 64'(BAND_LIMIT_PCT[i]) * 64'(SOUND_DIV) * 64'(cfg_range))
                return BAND_W'(i);
        return BAND_BEYOND;
    endfunction

    // one microsecond tick of the ranger
    function automatic range_reading_t advance_ranger(input logic echo);
        range_reading_t r;
        logic [63:0]    dist_full;
        if (trig_ph == PH_IDLE && period_left == '0)
        begin
            trig_ph     = PH_LOW;
            phase_ticks = '0;
            period_left = cfg_period;
        end
        r.trig = (trig_ph == PH_HIGH);
        r.done = 1'b0;
        case (trig_ph)
            PH_LOW:
            begin
                phase_ticks++;
                if (phase_ticks >= LOW_TICKS)
                begin
                    phase_ticks = '0;
                    trig_ph     = (cfg_pulse == '0) ? PH_IDLE : PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                phase_ticks++;
                if (phase_ticks >= cfg_pulse)
                begin
                    phase_ticks = '0;
                    trig_ph     = PH_IDLE;
                end
            end
            default:
            begin
                trig_ph     = PH_IDLE;
                phase_ticks = '0;
            end
        endcase

        ms_ticks++;
        if (ms_ticks >= TICKS_PER_MS)
        begin
            ms_ticks = '0;
            if (period_left != '0)
                period_left--;
        end

        if (echo && !echo_prev)
        begin
            echo_busy  = 1'b1;
            echo_ticks = ECHO_WIDTH_BITS'(1);
        end
        else if (echo && echo_busy)
        begin
            if (echo_ticks != '1)
                echo_ticks++;
        end
        else if (!echo && echo_prev && echo_busy)
        begin
            dist_full = (64'(echo_ticks) << 4) / 64'(SOUND_DIV);
            dist_q4   = (dist_full > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(dist_full);
            band_now  = band_for(echo_ticks);
            echo_busy = 1'b0;
            r.done    = 1'b1;
        end
        echo_prev = echo;

        r.distance = dist_q4;
        r.band     = band_now;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (addr)
            CFG_TRIGGER_PERIOD: cfg_period = PERIOD_W'(value);
            CFG_TRIGGER_PULSE:  cfg_pulse  = PULSE_W'(value);
            CFG_MAX_RANGE:      cfg_range  = RANGE_W'(value);
            default: ;
        endcase
    endtask

    // sender works in bursts with random gaps between them
    task automatic send_tick(input logic echo);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, echo};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_readings.push_back(advance_ranger(echo));
        burst_left--;
    endtask

    task automatic send_echo_pulse(input int width, input int low_after);
        repeat (width) send_tick(1'b1);
        repeat (low_after) send_tick(1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset values: trigger starts on the first tick, shortest echo
    task automatic test_reset_defaults();
        repeat (16) send_tick(1'b0);
        send_echo_pulse(1, 2);
        drain();
    endtask

    task automatic test_band_edges();
        // exactly five percent stays in band 0, one tick more goes to band 1
        write_reg(CFG_MAX_RANGE, 10);
        send_echo_pulse(29, 2);
        send_echo_pulse(30, 2);
        drain();
        // full scale and just beyond
        write_reg(CFG_MAX_RANGE, 1);
        send_echo_pulse(58, 2);
        send_echo_pulse(59, 2);
        drain();
        // zero range puts everything beyond
        write_reg(CFG_MAX_RANGE, 0);
        send_echo_pulse(2, 2);
        drain();
    endtask

    task automatic test_short_sequences();
        // zero period with zero pulse: back-to-back low phases, trigger never high
        write_reg(CFG_TRIGGER_PERIOD, 0);
        write_reg(CFG_TRIGGER_PULSE, 0);
        repeat (12) send_tick(1'b0);
        drain();
        write_reg(CFG_TRIGGER_PULSE, 1);
        repeat (12) send_tick(1'b0);
        drain();
    endtask

    task automatic test_random_phase(input int n_ticks, input bit with_holdoff);
        int sent;
        int width;
        int low_after;
        int span;
        int unsigned pick;
        case ($urandom_range(0, 3))
            0:       pick = 0;
            1:       pick = 1;
            2:       pick = 1023;
            default: pick = $urandom_range(2, 5);
        endcase
        write_reg(CFG_TRIGGER_PERIOD, pick);
        case ($urandom_range(0, 3))
            0:       pick = 0;
            1:       pick = 1;
            2:       pick = 255;
            default: pick = $urandom_range(2, 20);
        endcase
        write_reg(CFG_TRIGGER_PULSE, pick);
        case ($urandom_range(0, 4))
            0:       pick = 0;
            1:       pick = 1023;
            default: pick = $urandom_range(1, 3);
        endcase
        write_reg(CFG_MAX_RANGE, pick);

        // widths reach past full scale for the small ranges
        span = (cfg_range <= 3) ? 58 * cfg_range + 8 : 60;
        if (with_holdoff)
            hold_cycles = HOLD_CYCLES;
        sent = 0;
        while (sent < n_ticks)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                width     = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12)
                                                        : $urandom_range(1, span);
                low_after = $urandom_range(1, 6);
                send_echo_pulse(width, low_after);
                sent += width + low_after;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_tick(1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        drain();
    endtask

    // receiver stalls on its own pattern, with an occasional long hold-off
    initial
    begin : ready_pattern
        int ready_run;
        int stall_run;
        ready_run = 0;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (ready_run > 0)
            begin
                m_tready <= 1'b1;
                ready_run--;
            end
            else if (stall_run > 0)
            begin
                m_tready <= 1'b0;
                stall_run--;
            end
            else
            begin
                m_tready <= 1'b1;
                ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 19);
                stall_run = $urandom_range(0, 4);
            end
        end
    end

    always @(posedge clk)
    begin : check_readings
        range_reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading transfer: tdata=%h", m_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_tdata[TRIG_BIT] !== want.trig
                    || m_tdata[DONE_BIT] !== want.done
                    || m_tdata[DIST_LSB +: DIST_W] !== want.distance
                    || m_tdata[BAND_LSB +: BAND_W] !== want.band
                    || m_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"reading mismatch: expected trig=%0d done=%0d dist=%0d band=%0d",
                                  " got trig=%0d done=%0d dist=%0d band=%0d pad=%h"},
                                 want.trig, want.done, want.distance, want.band,
                                 m_tdata[TRIG_BIT], m_tdata[DONE_BIT],
                                 m_tdata[DIST_LSB +: DIST_W], m_tdata[BAND_LSB +: BAND_W],
                                 m_tdata[OUT_TDATA_W-1:PAD_LSB]);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(30_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : run_tests
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_band_edges();
        test_short_sequences();
        for (int p = 0; p < 4; p++)
            test_random_phase(70, p == 1);
        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
